// File: hdl/dual_wheel_speed_pid_unit_defines.svh
// assertion macros shared by the speed controller
`ifndef DUAL_WHEEL_SPEED_PID_UNIT_DEFINES_SVH
`define DUAL_WHEEL_SPEED_PID_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define DWSP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dwsp check failed");
`define DWSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dwsp check failed");
`else
`define DWSP_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define DWSP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: hdl/dwsp_pkg.sv
package dwsp_pkg;

  localparam int PERIOD_W = 16;
  localparam int SUM_W    = 22;
  localparam int DRIVE_W  = 13;
  localparam int SPEED_W  = 16;
  localparam int GAIN_W   = 16;
  localparam int TARGET_W = 10;
  localparam int ERR_W    = 17;
  localparam int IDX_W    = 3;
  localparam int DIV_CNT_W = $clog2(SUM_W);

  localparam int RPM_NUMERATOR = 2000000;
  localparam int PRESET_FACTOR = 40;
  localparam int DRIVE_MIN     = 2;
  localparam int DRIVE_MAX     = 7500;

  localparam logic [IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
  localparam logic [IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
  localparam logic [IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
  localparam logic [IDX_W-1:0] REG_TARGET_LEFT  = 3'd3;
  localparam logic [IDX_W-1:0] REG_TARGET_RIGHT = 3'd4;

  typedef struct packed {
    logic signed [GAIN_W:0]   pi_gain;
    logic signed [GAIN_W-1:0] d_gain;
  } gains_t;

  typedef struct packed {
    logic               done;
    logic [DRIVE_W-1:0] duty;
    logic [SPEED_W-1:0] speed;
  } lane_stat_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] left_drive;
    logic [DRIVE_W-1:0] right_drive;
    logic               updated;
    logic [SPEED_W-1:0] left_speed;
    logic [SPEED_W-1:0] right_speed;
  } result_t;

endpackage

// File: hdl/dwsp_div.sv
module dwsp_div
  import dwsp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [SUM_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [SUM_W-1:0]     rem;
  logic [SUM_W-1:0]     quo;
  logic [SUM_W-1:0]     dvs;
  logic [SUM_W:0]       rem_shift;
  logic [SUM_W:0]       rem_trial;
  logic                 fits;

  // restoring division, one quotient bit a cycle; a zero divisor gives all ones
  always_comb begin
    rem_shift = {rem, quo[SUM_W-1]};
    fits      = rem_shift >= {1'b0, dvs};
    rem_trial = fits ? (rem_shift - {1'b0, dvs}) : rem_shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= DIV_CNT_W'(SUM_W - 1);
        rem   <= '0;
        quo   <= dividend;
        dvs   <= divisor;
      end else if (busy) begin
        rem <= rem_trial[SUM_W-1:0];
        quo <= {quo[SUM_W-2:0], fits};
        count <= count - 1'b1;
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// File: hdl/dwsp_lane.sv
module dwsp_lane
  import dwsp_pkg::*;
#(
  parameter int SAMPLES = 10
)
(
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic                close,
  input  logic [PERIOD_W-1:0] period,
  input  logic                preset,
  input  logic [TARGET_W-1:0] preset_target,
  input  gains_t              gains,
  output lane_stat_t          stat
);

  localparam int ACC_W = 36;
  localparam int MUL_W = ERR_W + 1;
  localparam int RECIP_SHIFT = SUM_W + $clog2(SAMPLES);
  localparam int RECIP_W     = SUM_W + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam longint RECIP   = ((longint'(1) << RECIP_SHIFT) + longint'(SAMPLES) - 1)
                               / longint'(SAMPLES);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV_AVG, S_DIV_RPM, S_MUL_P, S_MUL_D, S_SUM, S_CLAMP, S_DONE
  } state_t;

  state_t                    state;
  logic [SUM_W-1:0]          period_sum;
  logic [SUM_W-1:0]          sum_next;
  logic [TARGET_W-1:0]       target;
  logic [DRIVE_W-1:0]        duty;
  logic [SPEED_W-1:0]        rpm_hold;
  logic signed [ERR_W-1:0]   last_err;
  logic signed [ERR_W-1:0]   err;
  logic signed [ACC_W-1:0]   prod;
  logic signed [ACC_W-1:0]   acc;

  logic [PROD_W-1:0]         avg_prod;
  logic [SUM_W-1:0]          avg;
  logic                      div_go;
  logic [SUM_W-1:0]          div_dividend;
  logic [SUM_W-1:0]          div_divisor;
  logic                      div_done;
  logic [SUM_W-1:0]          div_quo;
  logic [SPEED_W-1:0]        rpm_sat;
  logic signed [MUL_W-1:0]   derr;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic [15:0]               preset_raw;
  logic [DRIVE_W-1:0]        preset_duty;

  assign sum_next = period_sum + {{(SUM_W-PERIOD_W){1'b0}}, period};

  // window average by reciprocal multiply, exact for any sum that fits the accumulator
  assign avg_prod = PROD_W'(period_sum) * PROD_W'(RECIP);
  assign avg      = SUM_W'(avg_prod >> RECIP_SHIFT);

  // the divider then turns the average into rpm
  assign div_go       = (state == S_DIV_AVG);
  assign div_dividend = SUM_W'(RPM_NUMERATOR);
  assign div_divisor  = avg;

  dwsp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign rpm_sat = (|div_quo[SUM_W-1:SPEED_W]) ? {SPEED_W{1'b1}} : div_quo[SPEED_W-1:0];

  // one shared multiplier: (kp + ki) * err first, then kd * change of error
  assign derr  = {err[ERR_W-1], err} - {last_err[ERR_W-1], last_err};
  assign mul_a = (state == S_MUL_P) ? {gains.pi_gain[GAIN_W], gains.pi_gain}
                                    : {{(MUL_W-GAIN_W){gains.d_gain[GAIN_W-1]}}, gains.d_gain};
  assign mul_b = (state == S_MUL_P) ? {err[ERR_W-1], err} : derr;

  assign preset_raw  = 16'(preset_target) * 16'(PRESET_FACTOR);
  assign preset_duty = (preset_raw > 16'(DRIVE_MAX)) ? DRIVE_W'(DRIVE_MAX)
                                                     : preset_raw[DRIVE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      period_sum <= '0;
      target     <= '0;
      duty       <= '0;
      rpm_hold   <= '0;
      last_err   <= '0;
    end else begin
      if (preset) begin
        target <= preset_target;
        duty   <= preset_duty;
      end
      case (state)
        S_IDLE: begin
          // a closing sample is added into the sum, which is held while the average is formed
          if (take) begin
            period_sum <= sum_next;
            if (close) state <= S_DIV_AVG;
          end
        end
        S_DIV_AVG: begin
          period_sum <= '0;
          state      <= S_DIV_RPM;
        end
        S_DIV_RPM: begin
          if (div_done) begin
            rpm_hold <= rpm_sat;
            err      <= $signed({{(ERR_W-TARGET_W){1'b0}}, target})
                      - $signed({1'b0, rpm_sat});
            state    <= S_MUL_P;
          end
        end
        S_MUL_P: begin
          prod  <= ACC_W'(mul_a * mul_b);
          state <= S_MUL_D;
        end
        S_MUL_D: begin
          acc   <= $signed({{(ACC_W-DRIVE_W){1'b0}}, duty}) + prod;
          prod  <= ACC_W'(mul_a * mul_b);
          state <= S_SUM;
        end
        S_SUM: begin
          acc      <= acc + prod;
          last_err <= err;
          state    <= S_CLAMP;
        end
        S_CLAMP: begin
          if (acc < $signed(ACC_W'(DRIVE_MIN))) duty <= DRIVE_W'(DRIVE_MIN);
          else if (acc > $signed(ACC_W'(DRIVE_MAX))) duty <= DRIVE_W'(DRIVE_MAX);
          else duty <= acc[DRIVE_W-1:0];
          state <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign stat.done  = (state == S_DONE);
  assign stat.duty  = duty;
  assign stat.speed = rpm_hold;

endmodule

// File: hdl/dual_wheel_speed_pid_unit.sv
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall | left_period, right_period
// out     | output    | out_valid/out_stall | left_drive, right_drive, updated,
//         |           |                     | left_speed, right_speed
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// an item that does not close a window has its result registered on acceptance
// a window-closing item then goes through the reciprocal average, the bit-serial rpm
// division in each lane, loading speed and error, four multiply, add and clamp steps,
// and the merge of the lanes; the input stalls for all of them
// one result may wait in a holding slot while the output is stalled, stalling the input
// rst is synchronous, clears gains, targets, drives, sums and the window count

`include "dual_wheel_speed_pid_unit_defines.svh"

module dual_wheel_speed_pid_unit
  import dwsp_pkg::*;
#(
  parameter int SAMPLES = 10
)
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [PERIOD_W-1:0] left_period,
  input  logic [PERIOD_W-1:0] right_period,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [DRIVE_W-1:0]  left_drive,
  output logic [DRIVE_W-1:0]  right_drive,
  output logic                updated,
  output logic [SPEED_W-1:0]  left_speed,
  output logic [SPEED_W-1:0]  right_speed,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [GAIN_W-1:0]   cfg_data
);

  localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

  logic [CNT_W-1:0]         count;
  logic [CNT_W:0]           count_inc;
  logic                     close;
  logic                     accept;
  logic                     busy;
  logic                     lanes_done;
  logic                     finish;
  logic                     out_free;
  logic                     pend_valid;
  logic                     cfg_write;
  logic                     drive_ok;
  logic signed [GAIN_W-1:0] prop_gain;
  logic signed [GAIN_W-1:0] integ_gain;
  logic signed [GAIN_W-1:0] deriv_gain;
  gains_t                   gains;
  lane_stat_t               left_stat;
  lane_stat_t               right_stat;
  result_t                  res;
  result_t                  pend;
  result_t                  out_reg;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  assign in_stall  = busy || pend_valid;
  assign accept    = in_valid && !in_stall;
  assign count_inc = {1'b0, count} + 1'b1;
  assign close     = (count_inc == (CNT_W+1)'(SAMPLES));

  assign gains.pi_gain = {prop_gain[GAIN_W-1], prop_gain} + {integ_gain[GAIN_W-1], integ_gain};
  assign gains.d_gain  = deriv_gain;

  dwsp_lane #(.SAMPLES(SAMPLES)) u_left (
    .clk           (clk),
    .rst           (rst),
    .take          (accept),
    .close         (close),
    .period        (left_period),
    .preset        (cfg_write && cfg_index == REG_TARGET_LEFT),
    .preset_target (cfg_data[TARGET_W-1:0]),
    .gains         (gains),
    .stat          (left_stat)
  );

  dwsp_lane #(.SAMPLES(SAMPLES)) u_right (
    .clk           (clk),
    .rst           (rst),
    .take          (accept),
    .close         (close),
    .period        (right_period),
    .preset        (cfg_write && cfg_index == REG_TARGET_RIGHT),
    .preset_target (cfg_data[TARGET_W-1:0]),
    .gains         (gains),
    .stat          (right_stat)
  );

  // merge both lanes into one result transaction
  assign lanes_done = left_stat.done && right_stat.done;
  assign finish     = (accept && !close) || (busy && lanes_done);
  assign out_free   = !out_valid || !out_stall;

  assign res.left_drive  = left_stat.duty;
  assign res.right_drive = right_stat.duty;
  assign res.updated     = busy;
  assign res.left_speed  = left_stat.speed;
  assign res.right_speed = right_stat.speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= '0;
      integ_gain <= '0;
      deriv_gain <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PROP_GAIN:  prop_gain  <= cfg_data;
        REG_INTEG_GAIN: integ_gain <= cfg_data;
        REG_DERIV_GAIN: deriv_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      busy       <= 1'b0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= close ? '0 : count_inc[CNT_W-1:0];
        if (close) busy <= 1'b1;
      end
      if (busy && lanes_done) busy <= 1'b0;

      if (out_free) begin
        if (pend_valid) begin
          out_reg    <= pend;
          out_valid  <= 1'b1;
          pend_valid <= 1'b0;
        end else if (finish) begin
          out_reg   <= res;
          out_valid <= 1'b1;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (finish) begin
        pend       <= res;
        pend_valid <= 1'b1;
      end
    end
  end

  assign left_drive  = out_reg.left_drive;
  assign right_drive = out_reg.right_drive;
  assign updated     = out_reg.updated;
  assign left_speed  = out_reg.left_speed;
  assign right_speed = out_reg.right_speed;

  assign drive_ok = (left_drive <= DRIVE_W'(DRIVE_MAX)) && (right_drive <= DRIVE_W'(DRIVE_MAX));

  `DWSP_ASSERT_NOW(a_pend_behind_out, clk, rst, pend_valid, out_valid)
  `DWSP_ASSERT_NOW(a_busy_no_pend, clk, rst, busy, !pend_valid)
  `DWSP_ASSERT_NEXT(a_close_starts_lanes, clk, rst, accept && close, busy)
  `DWSP_ASSERT_NOW(a_drive_range, clk, rst, out_valid, drive_ok)

endmodule

// File: tb/speed_pid_checker.sv
`timescale 1ns / 1ps

module speed_pid_checker
  import dwsp_pkg::*;
#(
  parameter int SAMPLES = 10
)
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [PERIOD_W-1:0] left_period,
  input  logic [PERIOD_W-1:0] right_period,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [DRIVE_W-1:0]  left_drive,
  input  logic [DRIVE_W-1:0]  right_drive,
  input  logic                updated,
  input  logic [SPEED_W-1:0]  left_speed,
  input  logic [SPEED_W-1:0]  right_speed,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [GAIN_W-1:0]   cfg_data,
  output int                  errors,
  output int                  pending
);

  logic signed [GAIN_W-1:0] kp, ki, kd;
  logic [TARGET_W-1:0]      tgt_l, tgt_r;
  logic [SUM_W-1:0]         sum_l, sum_r;
  int unsigned              window_cnt;
  logic [DRIVE_W-1:0]       duty_l, duty_r;
  logic signed [ERR_W-1:0]  err_l, err_r;
  logic [SPEED_W-1:0]       rpm_l, rpm_r;
  result_t                  drive_results[$];

  function automatic logic [SPEED_W-1:0] sum_to_rpm(input logic [SUM_W-1:0] sum);
    longint avg, q;
    avg = longint'(sum) / SAMPLES;
    if (avg == 0) return '1;
    q = RPM_NUMERATOR / avg;
    return (q > 65535) ? '1 : q[SPEED_W-1:0];
  endfunction

  function automatic logic [DRIVE_W-1:0] preset_duty(input logic [TARGET_W-1:0] t);
    int d;
    d = int'(t) * PRESET_FACTOR;
    return (d > DRIVE_MAX) ? DRIVE_W'(DRIVE_MAX) : DRIVE_W'(d);
  endfunction

  // incremental pid step, all terms at 64 bits so nothing wraps before the clamp
  function automatic logic [DRIVE_W-1:0] next_duty(
    input  logic [DRIVE_W-1:0]      duty,
    input  logic [TARGET_W-1:0]     target,
    input  logic [SPEED_W-1:0]      rpm,
    input  logic signed [ERR_W-1:0] last_err,
    output logic signed [ERR_W-1:0] new_err
  );
    longint e, de, u;
    e  = longint'(target) - longint'(rpm);
    de = e - longint'(last_err);
    u  = longint'(duty) + longint'(kp) * e + longint'(ki) * e + longint'(kd) * de;
    new_err = e[ERR_W-1:0];
    if (u < DRIVE_MIN) u = DRIVE_MIN;
    if (u > DRIVE_MAX) u = DRIVE_MAX;
    return u[DRIVE_W-1:0];
  endfunction

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t r;
    if (rst) begin
      kp = '0; ki = '0; kd = '0;
      tgt_l = '0; tgt_r = '0;
      sum_l = '0; sum_r = '0;
      window_cnt = 0;
      duty_l = '0; duty_r = '0;
      err_l = '0; err_r = '0;
      rpm_l = '0; rpm_r = '0;
      drive_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PROP_GAIN:  kp = cfg_data;
          REG_INTEG_GAIN: ki = cfg_data;
          REG_DERIV_GAIN: kd = cfg_data;
          REG_TARGET_LEFT: begin
            tgt_l  = cfg_data[TARGET_W-1:0];
            duty_l = preset_duty(tgt_l);
          end
          REG_TARGET_RIGHT: begin
            tgt_r  = cfg_data[TARGET_W-1:0];
            duty_r = preset_duty(tgt_r);
          end
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        sum_l = sum_l + left_period;
        sum_r = sum_r + right_period;
        window_cnt++;
        r.updated = 1'b0;
        if (window_cnt >= SAMPLES) begin
          rpm_l  = sum_to_rpm(sum_l);
          rpm_r  = sum_to_rpm(sum_r);
          duty_l = next_duty(duty_l, tgt_l, rpm_l, err_l, err_l);
          duty_r = next_duty(duty_r, tgt_r, rpm_r, err_r, err_r);
          sum_l = '0;
          sum_r = '0;
          window_cnt = 0;
          r.updated = 1'b1;
        end
        r.left_drive  = duty_l;
        r.right_drive = duty_r;
        r.left_speed  = rpm_l;
        r.right_speed = rpm_r;
        drive_results.push_back(r);
      end

      if (out_valid && !out_stall) begin
        if (drive_results.size() == 0) begin
          errors++;
          $display("%0t: result transaction with none expected, actual drives %0d/%0d",
                   $time, left_drive, right_drive);
        end else begin
          r = drive_results.pop_front();
          compare_field("left_drive", r.left_drive, left_drive);
          compare_field("right_drive", r.right_drive, right_drive);
          compare_field("updated", r.updated, updated);
          compare_field("left_speed", r.left_speed, left_speed);
          compare_field("right_speed", r.right_speed, right_speed);
        end
      end
    end
    pending = drive_results.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import dwsp_pkg::*;

  localparam int SAMPLES = 10;
  localparam int LIMIT   = 400000;
  localparam int PHASES  = 8;
  localparam int PHASE_ITEMS = 135;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [PERIOD_W-1:0] left_period = '0;
  logic [PERIOD_W-1:0] right_period = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [DRIVE_W-1:0]  left_drive, right_drive;
  logic                updated;
  logic [SPEED_W-1:0]  left_speed, right_speed;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [GAIN_W-1:0]   cfg_data = '0;

  int errors, pending;
  int cycles = 0;
  bit calm = 1'b0;

  dual_wheel_speed_pid_unit #(.SAMPLES(SAMPLES)) u_dut (.*);

  speed_pid_checker #(.SAMPLES(SAMPLES)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .left_period(left_period), .right_period(right_period),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_drive(left_drive), .right_drive(right_drive), .updated(updated),
    .left_speed(left_speed), .right_speed(right_speed),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk)
    out_stall = !calm && ($urandom_range(0, 99) < 25);

  task automatic send_periods(input logic [PERIOD_W-1:0] lp, input logic [PERIOD_W-1:0] rp);
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    left_period  = lp;
    right_period = rp;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // registers only change once every result has drained
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic program_loop(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                              input logic [GAIN_W-1:0] d, input logic [GAIN_W-1:0] tl,
                              input logic [GAIN_W-1:0] tr);
    drain();
    write_reg(REG_PROP_GAIN, p);
    write_reg(REG_INTEG_GAIN, i);
    write_reg(REG_DERIV_GAIN, d);
    write_reg(REG_TARGET_LEFT, tl);
    write_reg(REG_TARGET_RIGHT, tr);
    // indexes past the last register must be ignored
    if ($urandom_range(0, 1))
      write_reg(IDX_W'($urandom_range(REG_TARGET_RIGHT + 1, 7)), GAIN_W'($urandom));
  endtask

  // mostly periods near the one that gives the target speed, so the loop stays in range
  function automatic logic [PERIOD_W-1:0] pick_period(input int target);
    int r, nom, jit;
    r = $urandom_range(0, 99);
    if (r < 60 && target > 0) begin
      nom = 2000000 / target;
      if (nom > 65535) nom = 65535;
      jit = nom / 8;
      nom = nom - jit + int'($urandom_range(0, 2 * jit));
      if (nom > 65535) nom = 65535;
      return PERIOD_W'(nom);
    end
    if (r < 85) return PERIOD_W'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0: return '0;
      1: return PERIOD_W'(1);
      2: return '1;
      default: return PERIOD_W'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain(input bit wide);
    int s;
    s = int'($urandom_range(0, 16)) - 8;
    return wide ? GAIN_W'($urandom) : GAIN_W'(s);
  endfunction

  function automatic int pick_target();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 1023;
      default: return $urandom_range(0, 1023);
    endcase
  endfunction

  initial begin
    int tl, tr;
    bit wide;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // zero average on the left, overflowing quotient on the right, drives pinned low
    program_loop(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h0000);
    repeat (SAMPLES) send_periods(16'h0000, 16'h0001);

    // slowest wheels with a large jump in error, drives pinned high
    program_loop(16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h03FF);
    write_reg(3'd5, 16'hFFFF);
    write_reg(3'd6, 16'h0000);
    write_reg(3'd7, 16'hA5A5);
    repeat (SAMPLES) send_periods(16'hFFFF, 16'hFFFF);
    send_periods(16'h0001, 16'h8000);
    send_periods(16'h8000, 16'h0001);
    send_periods(16'h5555, 16'hAAAA);
    send_periods(16'hAAAA, 16'h5555);
    send_periods(16'h00FF, 16'hFF00);

    for (int ph = 0; ph < PHASES; ph++) begin
      tl = pick_target();
      tr = pick_target();
      wide = ($urandom_range(0, 3) == 0);
      if (ph == 0)
        program_loop('0, '0, '0, {6'($urandom), 10'(tl)}, {6'($urandom), 10'(tr)});
      else
        program_loop(pick_gain(wide), pick_gain(wide), pick_gain(wide),
                     {6'($urandom), 10'(tl)}, {6'($urandom), 10'(tr)});
      calm = (ph == 3);
      repeat (PHASE_ITEMS) send_periods(pick_period(tl), pick_period(tr));
      calm = 1'b0;
    end

    drain();
    repeat (60) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// File: dual_wheel_speed_pid_unit.f
+incdir+hdl
hdl/dwsp_pkg.sv
hdl/dwsp_div.sv
hdl/dwsp_lane.sv
hdl/dual_wheel_speed_pid_unit.sv
tb/speed_pid_checker.sv
tb/tb.sv
